### design/simplex_noise_3d_macros.svh
`ifndef SIMPLEX_NOISE_3D_MACROS_SVH
`define SIMPLEX_NOISE_3D_MACROS_SVH

// check that holds in the same cycle as the trigger
`define SN3D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that holds in the cycle after the trigger
`define SN3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sn3d_pkg.sv
package sn3d_pkg;

	localparam int TABLE_BITS = 8;
	localparam int FRAC_BITS  = 16;

	// reciprocal of 3 for 35-bit operands, shift 38
	localparam logic [36:0] SKEW_M   = 37'd91625968982;
	// reciprocal of 3 for 23-bit operands, shift 24
	localparam logic [22:0] UNSKEW_M = 23'd5592406;

	localparam logic signed [19:0] ONE_Q  = 20'sd65536;
	localparam logic signed [42:0] FALL_Q = 43'sd2576980378;

	// per-corner unskew offset: none, G1, G2, G3
	localparam logic signed [19:0] CORNER_G [4] = '{20'sd0, 20'sd10923, 20'sd21845, 20'sd32768};

	typedef logic [TABLE_BITS-1:0] tab_t;
	typedef logic signed [19:0] ofs_t;

	function automatic logic [63:0] xorshift(logic [63:0] w);
		logic [63:0] a;
		logic [63:0] b;
		a = w ^ (w << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	// floor(r * 2^15 / 3) for a remainder of 0..2
	function automatic logic [15:0] unskew_frac(logic [1:0] r);
		logic [15:0] f;
		unique case (r)
			2'd1: f = 16'd10922;
			2'd2: f = 16'd21845;
			default: f = 16'd0;
		endcase
		return f;
	endfunction

	// h mod 12 through a reciprocal multiply, exact for 8-bit h
	function automatic logic [3:0] mod12(tab_t h);
		logic [15:0] p;
		logic [4:0] q;
		logic [7:0] r;
		p = 16'(h) * 16'd171;
		q = p[15:11];
		r = h - 8'(q) * 8'd12;
		return r[3:0];
	endfunction

	// which axes step by one lattice unit at a corner
	function automatic logic [2:0] corner_off(logic [1:0] c, logic [2:0] o1, logic [2:0] o2);
		logic [2:0] o;
		unique case (c)
			2'd0: o = 3'b000;
			2'd1: o = o1;
			2'd2: o = o2;
			2'd3: o = 3'b111;
		endcase
		return o;
	endfunction

	function automatic logic signed [21:0] grad_dot(logic [3:0] g, ofs_t dx, ofs_t dy, ofs_t dz);
		logic signed [21:0] ex;
		logic signed [21:0] ey;
		logic signed [21:0] ez;
		logic signed [21:0] r;
		ex = 22'(dx);
		ey = 22'(dy);
		ez = 22'(dz);
		unique case (g)
			4'd0:  r = ex + ey;
			4'd1:  r = ey - ex;
			4'd2:  r = ex - ey;
			4'd3:  r = -ex - ey;
			4'd4:  r = ex + ez;
			4'd5:  r = ez - ex;
			4'd6:  r = ex - ez;
			4'd7:  r = -ex - ez;
			4'd8:  r = ey + ez;
			4'd9:  r = ez - ey;
			4'd10: r = ey - ez;
			4'd11: r = -ey - ez;
			default: r = 22'sd0;
		endcase
		return r;
	endfunction

endpackage

### design/simplex_noise_3d.sv
// pipeline: 16 register stages from input transfer to result valid
// throughput: one point per cycle via dual-port table copies, when not stalled or filling
// reset: asynchronous, active low; after reset and after every seed write the hash table
// is refilled, all 256 entries (one xorshift draw per cycle), in_ready stays low meanwhile
module simplex_noise_3d import sn3d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [63:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [31:0] z_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);

	typedef enum logic {ST_FILL, ST_RUN} st_t;

	// table fill sequencer
	st_t         st_q;
	logic [63:0] gen_q;
	tab_t        fill_idx_q;
	logic [63:0] draw;
	logic        fill_we;

	// pipeline control: bit n holds the valid of stage n+1
	logic [15:0] vld_q;
	logic        adv;

	// five copies of the hash table, two read ports each
	tab_t mem_a [256];
	tab_t mem_b [256];
	tab_t mem_c [256];
	tab_t mem_d [256];
	tab_t mem_e [256];

	// stage payloads
	logic signed [31:0] p_s1 [3];
	logic [34:0]        u_s1;
	logic signed [31:0] p_s2 [3];
	logic [54:0]        plo_s2;
	logic [53:0]        phi_s2;
	logic signed [31:0] p_s3 [3];
	logic signed [33:0] s_s3;
	logic signed [18:0] i_s4 [3];
	logic [15:0]        lo_s4 [3];
	logic signed [33:0] s_s4;
	logic [22:0]        m_s5;
	logic signed [34:0] xa_s5 [3];
	tab_t               idx_s5 [3];
	logic [45:0]        pr_s6;
	logic [22:0]        m_s6;
	logic signed [34:0] xa_s6 [3];
	tab_t               idx_s6 [3];
	logic signed [22:0] a_s7;
	logic [1:0]         r_s7;
	logic signed [34:0] xa_s7 [3];
	tab_t               idx_s7 [3];
	ofs_t               x0_s8 [3];
	tab_t               idx_s8 [3];
	ofs_t               x0_s9 [3];
	tab_t               idx_s9 [3];
	logic [2:0]         o1_s9;
	logic [2:0]         o2_s9;
	tab_t               h1a_s9;
	tab_t               h1b_s9;
	tab_t               h2_s10 [4];
	ofs_t               d_s10 [4][3];
	logic [2:0]         off_s10 [4];
	tab_t               ii_s10;
	tab_t               h3_s11 [4];
	logic signed [39:0] sq_s11 [4][3];
	ofs_t               d_s11 [4][3];
	logic [29:0]        t0_s12 [4];
	logic [3:0]         g_s12 [4];
	ofs_t               d_s12 [4][3];
	logic [59:0]        p1_s13 [4];
	logic signed [21:0] dot_s13 [4];
	logic [59:0]        p2_s14 [4];
	logic signed [21:0] dot_s14 [4];
	logic signed [52:0] term_s15 [4];
	logic signed [15:0] noise_s16;

	// table addresses
	tab_t addr1a;
	tab_t addr1b;
	tab_t addr2 [4];
	tab_t addr3 [4];
	logic [2:0] off9 [4];

	// ---------------------------------------------------------------
	// handshake: the whole pipeline moves unless the output is blocked
	// ---------------------------------------------------------------
	assign adv       = !vld_q[15] || out_ready;
	assign in_ready  = adv && (st_q == ST_RUN);
	assign out_valid = vld_q[15];
	assign noise_value = noise_s16;

	// ---------------------------------------------------------------
	// table fill: one xorshift draw per cycle into every copy
	// ---------------------------------------------------------------
	assign draw    = xorshift(gen_q);
	assign fill_we = (st_q == ST_FILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_FILL;
			gen_q      <= 64'd1;
			fill_idx_q <= '0;
		end else if (cfg_wen) begin
			// new seed restarts the fill
			st_q       <= ST_FILL;
			gen_q      <= cfg_wdata;
			fill_idx_q <= '0;
		end else if (st_q == ST_FILL) begin
			gen_q      <= draw;
			fill_idx_q <= fill_idx_q + 1'b1;
			if (fill_idx_q == '1) begin
				st_q <= ST_RUN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[14:0], in_valid && in_ready};
		end
	end

	// ---------------------------------------------------------------
	// table addressing per hash level
	// ---------------------------------------------------------------
	always_comb begin
		addr1a = idx_s8[2];
		addr1b = idx_s8[2] + 1'b1;
		for (int c = 0; c < 4; c++) begin
			off9[c]  = corner_off(2'(c), o1_s9, o2_s9);
			addr2[c] = idx_s9[1] + tab_t'(off9[c][1])
				+ (off9[c][2] ? h1b_s9 : h1a_s9);
			addr3[c] = ii_s10 + tab_t'(off_s10[c][0]) + h2_s10[c];
		end
	end

	// level one: z lookups, only kk and kk+1 are ever needed
	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem_a[fill_idx_q] <= draw[7:0];
		end
		if (adv) begin
			h1a_s9 <= mem_a[addr1a];
			h1b_s9 <= mem_a[addr1b];
		end
	end

	// level two: y lookups, corners 0/1 and 2/3
	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem_b[fill_idx_q] <= draw[7:0];
		end
		if (adv) begin
			h2_s10[0] <= mem_b[addr2[0]];
			h2_s10[1] <= mem_b[addr2[1]];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem_c[fill_idx_q] <= draw[7:0];
		end
		if (adv) begin
			h2_s10[2] <= mem_c[addr2[2]];
			h2_s10[3] <= mem_c[addr2[3]];
		end
	end

	// level three: x lookups give the gradient hash
	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem_d[fill_idx_q] <= draw[7:0];
		end
		if (adv) begin
			h3_s11[0] <= mem_d[addr3[0]];
			h3_s11[1] <= mem_d[addr3[1]];
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem_e[fill_idx_q] <= draw[7:0];
		end
		if (adv) begin
			h3_s11[2] <= mem_e[addr3[2]];
			h3_s11[3] <= mem_e[addr3[3]];
		end
	end

	// ---------------------------------------------------------------
	// arithmetic pipeline
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [72:0]        qsum;
		logic signed [34:0] xs;
		logic signed [20:0] n;
		logic [21:0]        q2;
		logic signed [37:0] tt;
		logic signed [37:0] x0w;
		logic [41:0]        r2;
		logic signed [42:0] rr;
		logic signed [54:0] sum;
		logic signed [28:0] v;
		if (adv) begin
			// s1: capture point, offset coordinate sum so it is never negative
			p_s1[0] <= x_coord;
			p_s1[1] <= y_coord;
			p_s1[2] <= z_coord;
			u_s1 <= 35'(35'(x_coord) + 35'(y_coord) + 35'(z_coord) + 35'sd12884901888);

			// s2: sum / 3 as two partial products
			p_s2   <= p_s1;
			plo_s2 <= 55'(u_s1[17:0]) * 55'(SKEW_M);
			phi_s2 <= 54'(u_s1[34:18]) * 54'(SKEW_M);

			// s3: skew s = floor(sum / 3)
			p_s3 <= p_s2;
			qsum = 73'({phi_s2, 18'd0}) + 73'(plo_s2);
			s_s3 <= 34'($signed({1'b0, qsum[71:38]}) - 35'sd4294967296);

			// s4: cell index and fraction of each skewed coordinate
			for (int a = 0; a < 3; a++) begin
				xs = 35'(p_s3[a]) + 35'(s_s3);
				i_s4[a]  <= xs[34:16];
				lo_s4[a] <= xs[15:0];
			end
			s_s4 <= s_s3;

			// s5: index sum, offset for the unskew divide
			n = 21'(i_s4[0]) + 21'(i_s4[1]) + 21'(i_s4[2]);
			m_s5 <= 23'(23'(n) + 23'sd3145728);
			for (int a = 0; a < 3; a++) begin
				xa_s5[a]  <= $signed({19'd0, lo_s4[a]}) - 35'(s_s4);
				idx_s5[a] <= i_s4[a][7:0];
			end

			// s6: index sum / 3
			pr_s6  <= 46'(m_s5) * 46'(UNSKEW_M);
			m_s6   <= m_s5;
			xa_s6  <= xa_s5;
			idx_s6 <= idx_s5;

			// s7: quotient and remainder
			q2 = pr_s6[45:24];
			r_s7  <= 2'(m_s6 - 23'(q2) * 23'd3);
			a_s7  <= $signed({1'b0, q2}) - 23'sd1048576;
			xa_s7 <= xa_s6;
			idx_s7 <= idx_s6;

			// s8: unskew t, first corner offset
			tt = (38'(a_s7) <<< 15) + $signed({22'd0, unskew_frac(r_s7)});
			for (int a = 0; a < 3; a++) begin
				x0w = 38'(xa_s7[a]) + tt;
				x0_s8[a] <= x0w[19:0];
			end
			idx_s8 <= idx_s7;

			// s9: tetrahedron choice
			x0_s9  <= x0_s8;
			idx_s9 <= idx_s8;
			if (x0_s8[0] >= x0_s8[1]) begin
				if (x0_s8[1] >= x0_s8[2]) begin
					o1_s9 <= 3'b001;
					o2_s9 <= 3'b011;
				end else if (x0_s8[0] >= x0_s8[2]) begin
					o1_s9 <= 3'b001;
					o2_s9 <= 3'b101;
				end else begin
					o1_s9 <= 3'b100;
					o2_s9 <= 3'b101;
				end
			end else begin
				if (x0_s8[1] < x0_s8[2]) begin
					o1_s9 <= 3'b100;
					o2_s9 <= 3'b110;
				end else if (x0_s8[0] < x0_s8[2]) begin
					o1_s9 <= 3'b010;
					o2_s9 <= 3'b110;
				end else begin
					o1_s9 <= 3'b010;
					o2_s9 <= 3'b011;
				end
			end

			// s10: offsets of the four corners
			ii_s10 <= idx_s9[0];
			for (int c = 0; c < 4; c++) begin
				off_s10[c] <= off9[c];
				for (int a = 0; a < 3; a++) begin
					d_s10[c][a] <= x0_s9[a] - (off9[c][a] ? ONE_Q : 20'sd0) + CORNER_G[c];
				end
			end

			// s11: squared distances
			d_s11 <= d_s10;
			for (int c = 0; c < 4; c++) begin
				for (int a = 0; a < 3; a++) begin
					sq_s11[c][a] <= d_s10[c][a] * d_s10[c][a];
				end
			end

			// s12: clamped falloff in q30, gradient index
			d_s12 <= d_s11;
			for (int c = 0; c < 4; c++) begin
				r2 = 42'(sq_s11[c][0]) + 42'(sq_s11[c][1]) + 42'(sq_s11[c][2]);
				rr = FALL_Q - $signed({1'b0, r2});
				t0_s12[c] <= rr[42] ? 30'd0 : rr[31:2];
				g_s12[c]  <= mod12(h3_s11[c]);
			end

			// s13: first square, gradient dot product
			for (int c = 0; c < 4; c++) begin
				p1_s13[c]  <= 60'(t0_s12[c]) * 60'(t0_s12[c]);
				dot_s13[c] <= grad_dot(g_s12[c], d_s12[c][0], d_s12[c][1], d_s12[c][2]);
			end

			// s14: second square
			dot_s14 <= dot_s13;
			for (int c = 0; c < 4; c++) begin
				p2_s14[c] <= 60'(p1_s13[c][59:30]) * 60'(p1_s13[c][59:30]);
			end

			// s15: corner terms
			for (int c = 0; c < 4; c++) begin
				term_s15[c] <= 53'($signed({1'b0, p2_s14[c][59:30]}) * 53'(dot_s14[c]));
			end

			// s16: sum, scale by 32 into q15, saturate
			sum = 55'(term_s15[0]) + 55'(term_s15[1]) + 55'(term_s15[2]) + 55'(term_s15[3]);
			v = sum[54:26];
			if (v > 29'sd32767) begin
				noise_s16 <= 16'sd32767;
			end else if (v < -29'sd32768) begin
				noise_s16 <= -16'sd32768;
			end else begin
				noise_s16 <= v[15:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`include "simplex_noise_3d_macros.svh"

	`SN3D_ASSERT_NOW(a_no_xfer_in_fill, in_valid && in_ready, st_q == ST_RUN, "input transfer during table fill")
	`SN3D_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(vld_q), "pipeline occupancy changed while stalled")
	`SN3D_ASSERT_NEXT(a_fill_ends, (st_q == ST_FILL) && (fill_idx_q == '1) && !cfg_wen, st_q == ST_RUN, "table fill did not end after the last entry")

endmodule

### tb/simplex_noise_3d_tb.sv
module simplex_noise_3d_tb;

	// scoreboard: own copy of the hash table and a queue of predicted noise values
	class noise_scoreboard;
		logic [7:0]          perm [256];
		logic [63:0]         gen_word;
		logic signed [15:0]  noise_q [$];
		int unsigned         n_points;
		int unsigned         n_checked;

		function void load_seed(logic [63:0] s);
			gen_word = s;
			for (int n = 0; n < 256; n++) begin
				gen_word ^= gen_word << 13;
				gen_word ^= gen_word >> 17;
				gen_word ^= gen_word << 5;
				perm[n] = gen_word[7:0];
			end
		endfunction

		function longint fdiv(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q--;
			return q;
		endfunction

		function int lattice_hash(logic [7:0] a, logic [7:0] b, logic [7:0] c);
			logic [7:0] h;
			h = perm[c];
			h = perm[8'(b + h)];
			h = perm[8'(a + h)];
			return int'(h) % 12;
		endfunction

		function longint corner_term(longint dx, longint dy, longint dz, int g);
			longint r;
			longint f;
			longint dot;
			r = 64'sd2576980378 - (dx * dx + dy * dy + dz * dz);
			if (r < 0)
				return 0;
			f = r >>> 2;
			f = (f * f) >>> 30;
			f = (f * f) >>> 30;
			case (g)
				0:  dot = dx + dy;
				1:  dot = dy - dx;
				2:  dot = dx - dy;
				3:  dot = -dx - dy;
				4:  dot = dx + dz;
				5:  dot = dz - dx;
				6:  dot = dx - dz;
				7:  dot = -dx - dz;
				8:  dot = dy + dz;
				9:  dot = dz - dy;
				10: dot = dy - dz;
				default: dot = -dy - dz;
			endcase
			return f * dot;
		endfunction

		// predict the noise for one accepted point
		function void note_point(logic signed [31:0] xc, logic signed [31:0] yc,
				logic signed [31:0] zc);
			longint x, y, z, s, i, j, k, t, x0, y0, z0, sum, v;
			longint one, g1, g2, g3;
			int o1 [3];
			int o2 [3];
			logic [7:0] ii, jj, kk;
			one = 65536; g1 = 10923; g2 = 21845; g3 = 32768;
			x = xc; y = yc; z = zc;
			s = fdiv(x + y + z, 3);
			i = fdiv(x + s, one);
			j = fdiv(y + s, one);
			k = fdiv(z + s, one);
			t = fdiv((i + j + k) * one, 6);
			x0 = x - i * one + t;
			y0 = y - j * one + t;
			z0 = z - k * one + t;
			// pick the tetrahedron from the offset ordering
			if (x0 >= y0) begin
				if (y0 >= z0) begin
					o1 = '{1, 0, 0}; o2 = '{1, 1, 0};
				end else if (x0 >= z0) begin
					o1 = '{1, 0, 0}; o2 = '{1, 0, 1};
				end else begin
					o1 = '{0, 0, 1}; o2 = '{1, 0, 1};
				end
			end else begin
				if (y0 < z0) begin
					o1 = '{0, 0, 1}; o2 = '{0, 1, 1};
				end else if (x0 < z0) begin
					o1 = '{0, 1, 0}; o2 = '{0, 1, 1};
				end else begin
					o1 = '{0, 1, 0}; o2 = '{1, 1, 0};
				end
			end
			// negative cell indices wrap modulo the table size
			ii = i[7:0]; jj = j[7:0]; kk = k[7:0];
			sum = corner_term(x0, y0, z0, lattice_hash(ii, jj, kk));
			sum += corner_term(x0 - o1[0] * one + g1, y0 - o1[1] * one + g1,
				z0 - o1[2] * one + g1,
				lattice_hash(8'(ii + o1[0]), 8'(jj + o1[1]), 8'(kk + o1[2])));
			sum += corner_term(x0 - o2[0] * one + g2, y0 - o2[1] * one + g2,
				z0 - o2[2] * one + g2,
				lattice_hash(8'(ii + o2[0]), 8'(jj + o2[1]), 8'(kk + o2[2])));
			sum += corner_term(x0 - one + g3, y0 - one + g3, z0 - one + g3,
				lattice_hash(8'(ii + 1), 8'(jj + 1), 8'(kk + 1)));
			v = fdiv(sum, 64'sd1 << 26);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			noise_q.push_back(16'(v));
			n_points++;
		endfunction

		// returns an empty string when the result matches
		function string check_noise(logic signed [15:0] got);
			logic signed [15:0] want;
			n_checked++;
			if (noise_q.size() == 0)
				return $sformatf("noise_value %0d with no point outstanding", got);
			want = noise_q.pop_front();
			if (got !== want)
				return $sformatf("noise_value got %0d want %0d (result %0d)",
					got, want, n_checked);
			return "";
		endfunction

		function int pending();
			return noise_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [63:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic signed [31:0] z_coord;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] noise_value;

	noise_scoreboard sb;
	int  n_errors;
	int  n_seeds;
	bit  rx_hold_req;   // request a long receiver hold-off
	bit  calm;          // no idling on either side

	simplex_noise_3d i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.noise_value(noise_value)
	);

	// 10 time unit clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		n_errors++;
		$display("mismatch: %s", msg);
	endtask

	// monitor both channels; sampled at the edge, before any update lands
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_point(x_coord, y_coord, z_coord);
			if (out_valid && out_ready) begin
				msg = sb.check_noise(noise_value);
				if (msg != "")
					report_mismatch(msg);
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= 4000) begin
				$display("watchdog expired with %0d results outstanding", sb.pending());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				rx_hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	// wait until every predicted result has come back, then let the pipe settle
	task automatic drain();
		// let the monitor note a transfer made at the current edge
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// seed write only while idle; the block refills its table afterwards
	task automatic write_seed(logic [63:0] s);
		in_valid <= 1'b0;
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.load_seed(s);
		n_seeds++;
	endtask

	// hold valid until the transfer; it is left high for the caller unless paused
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		in_valid <= 1'b1;
		x_coord  <= x;
		y_coord  <= y;
		z_coord  <= z;
		do
			@(posedge clk);
		while (!in_ready);
		if (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// coordinates mostly near the origin, sometimes over the whole range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0, 1:    return $urandom();
			2:       return {{8{1'($urandom_range(1))}}, 24'($urandom())};
			default: return 32'($signed(20'($urandom())));
		endcase
	endfunction

	task automatic send_random(int count);
		for (int n = 0; n < count; n++)
			send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		sb = new();
		sb.load_seed(64'd1);
		n_errors = 0;
		n_seeds  = 0;
		rx_hold_req = 1'b0;
		calm      = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		x_coord   = '0;
		y_coord   = '0;
		z_coord   = '0;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: origin, extremes, each tetrahedron, negative cells
		send_point(0, 0, 0);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(32'h7fffffff, 32'h80000000, 0);
		send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_point(19661, 13107, 6554);
		send_point(19661, 6554, 13107);
		send_point(6554, 13107, 19661);
		send_point(6554, 19661, 13107);
		send_point(13107, 19661, 6554);
		send_point(13107, 6554, 19661);
		send_point(32768, 32768, 32768);
		send_point(-19661, -13107, -6554);
		send_point(-300000, 450000, -1000);
		send_point(32'h00010000, 32'hffff0000, 32'h00008000);
		send_point(32'h55555555, 32'haaaaaaaa, 32'h12345678);
		send_point(32'haaaaaaaa, 32'h55555555, 32'hedcba987);

		// zero seed gives an all-zero table
		write_seed(64'd0);
		send_random(40);
		write_seed('1);
		send_random(40);

		// back-pressure: receiver holds off while the sender keeps offering
		write_seed({$urandom(), $urandom()});
		rx_hold_req = 1'b1;
		send_random(400);

		// sender pauses until everything is back
		in_valid <= 1'b0;
		drain();

		// stretch with no idling at all
		calm = 1'b1;
		send_random(300);
		calm = 1'b0;

		write_seed(64'h8000_0000_0000_0000);
		send_random(300);
		write_seed({$urandom(), $urandom()});
		send_random(300);
		write_seed(64'd1);
		send_random(300);

		in_valid <= 1'b0;
		drain();

		$display("run: %0d points predicted, %0d results checked, %0d seed writes",
			sb.n_points, sb.n_checked, n_seeds);
		$display("covered extremes, all six tetrahedra, zero and all-ones seeds, long stall");
		if (n_errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, sb.pending());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/sn3d_pkg.sv
design/simplex_noise_3d.sv
tb/simplex_noise_3d_tb.sv
